[design/ksc_pkg.sv]
package ksc_pkg;

  localparam int unsigned KEY_BYTES_DEF = 256;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = VAL_W + 1;

  // Printable alphabet: bytes 32..125, base 94
  localparam logic [SUM_W-1:0]  ASCII_BASE = SUM_W'(94);
  localparam logic [SUM_W-1:0]  BIN_BASE   = SUM_W'(256);
  localparam logic [BYTE_W-1:0] ASCII_LO   = BYTE_W'(32);
  localparam logic [BYTE_W-1:0] ASCII_HI   = BYTE_W'(125);

  // floor(t / 94) == (t * RECIP_M) >> RECIP_SH, exact for t < 2**SUM_W
  localparam int unsigned        RECIP_W  = 18;
  localparam int unsigned        RECIP_SH = 24;
  localparam logic [RECIP_W-1:0] RECIP_M  = RECIP_W'(178482);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_WAIT,
    ST_SUM,
    ST_MUL,
    ST_WB,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic latch;
    logic init;
    logic rd_issue;
    logic add_start;
    logic sum;
    logic mul;
    logic wb;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             stop;
    logic             top;
    logic             out_free;
  } ctl_sts_t;

  function automatic logic [BYTE_W-1:0] ascii_digit(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d;
    if (b < ASCII_LO) begin
      d = '0;
    end else if (b > ASCII_HI) begin
      d = ASCII_HI - ASCII_LO;
    end else begin
      d = b - ASCII_LO;
    end
    return d;
  endfunction

endpackage

[design/ksc_if.sv]
interface ksc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ksc_pkg::CMD_W-1:0]  cmd;
  logic [ksc_pkg::VAL_W-1:0]  add_value;
  logic [ksc_pkg::LEN_W-1:0]  start_length;
  logic [ksc_pkg::IDX_W-1:0]  read_index;

  modport source (output valid, cmd, add_value, start_length, read_index, input ready);
  modport sink   (input valid, cmd, add_value, start_length, read_index, output ready);
endinterface

interface ksc_out_if;
  logic                       valid;
  logic                       ready;
  logic [ksc_pkg::BYTE_W-1:0] key_byte;
  logic [ksc_pkg::LEN_W-1:0]  used_length;
  logic                       wrapped;

  modport source (output valid, key_byte, used_length, wrapped, input ready);
  modport sink   (input valid, key_byte, used_length, wrapped, output ready);
endinterface

interface ksc_cfg_if;
  logic valid;
  logic ready;
  logic ascii_only;

  modport source (output valid, ascii_only, input ready);
  modport sink   (input valid, ascii_only, output ready);
endinterface

[design/key_space_counter.sv]
// Sequence: init and unknown command go through decode and finish, read through decode,
//   read wait and finish, add through decode, then sum, multiply and write back per byte
//   the carry walks. A new item is taken only once the last is loaded for output; each
//   walked byte costs a registered key store read, a sum stage and a multiply stage.
// Reset (rst_ni low, asynchronous): controller idle, used length, wrap flag, mode and the
//   per-byte valid bits cleared; the key store reads as zero at once, no clearing pass.
module key_space_counter #(
  parameter int unsigned KEY_BYTES = ksc_pkg::KEY_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ksc_in_if.sink     in_i,
  ksc_out_if.source  out_o,
  ksc_cfg_if.sink    cfg_i
);

  ksc_pkg::ctl_cmd_t ctl_cmd;
  ksc_pkg::ctl_sts_t ctl_sts;

  // Mode always ready; the user must see it is only written while idle (unenforced).
  assign cfg_i.ready = 1'b1;

  // Controller: sequences one item at a time, walks the carry one byte per pass
  // through sum, multiply and write back.
  ksc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (ctl_sts),
    .cmd_o      (ctl_cmd)
  );

  // Datapath: key store, length and wrap state, digit arithmetic and the output
  // register, which holds a finished result while the next item is taken.
  ksc_datapath #(
    .KEY_BYTES (KEY_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctl_cmd),
    .sts_o          (ctl_sts),
    .cmd_code_i     (in_i.cmd),
    .add_value_i    (in_i.add_value),
    .start_length_i (in_i.start_length),
    .read_index_i   (in_i.read_index),
    .cfg_valid_i    (cfg_i.valid),
    .ascii_only_i   (cfg_i.ascii_only),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .key_byte_o     (out_o.key_byte),
    .used_length_o  (out_o.used_length),
    .wrapped_o      (out_o.wrapped)
  );

endmodule

[design/ksc_ctrl.sv]
module ksc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ksc_pkg::ctl_sts_t sts_i,
  output ksc_pkg::ctl_cmd_t cmd_o
);

  ksc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ksc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ksc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ksc_pkg::ST_DECODE;
        end
      end
      ksc_pkg::ST_DECODE: begin
        unique case (sts_i.cmd)
          ksc_pkg::CMD_INIT: begin
            cmd_o.init = 1'b1;
            state_d    = ksc_pkg::ST_FINISH;
          end
          ksc_pkg::CMD_ADD: begin
            cmd_o.add_start = 1'b1;
            state_d         = ksc_pkg::ST_SUM;
          end
          ksc_pkg::CMD_READ: begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ksc_pkg::ST_RD_WAIT;
          end
          default: begin
            state_d = ksc_pkg::ST_FINISH;
          end
        endcase
      end
      ksc_pkg::ST_RD_WAIT: begin
        state_d = ksc_pkg::ST_FINISH;
      end
      ksc_pkg::ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ksc_pkg::ST_MUL;
      end
      ksc_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ksc_pkg::ST_WB;
      end
      ksc_pkg::ST_WB: begin
        cmd_o.wb = 1'b1;
        // stop when the carry dies or runs off the top byte
        if (sts_i.stop || sts_i.top) begin
          state_d = ksc_pkg::ST_FINISH;
        end else begin
          state_d = ksc_pkg::ST_SUM;
        end
      end
      ksc_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ksc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ksc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/ksc_datapath.sv]
module ksc_datapath #(
  parameter int unsigned KEY_BYTES = ksc_pkg::KEY_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ksc_pkg::ctl_cmd_t          cmd_i,
  output ksc_pkg::ctl_sts_t          sts_o,
  input  logic [ksc_pkg::CMD_W-1:0]  cmd_code_i,
  input  logic [ksc_pkg::VAL_W-1:0]  add_value_i,
  input  logic [ksc_pkg::LEN_W-1:0]  start_length_i,
  input  logic [ksc_pkg::IDX_W-1:0]  read_index_i,
  input  logic                       cfg_valid_i,
  input  logic                       ascii_only_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [ksc_pkg::BYTE_W-1:0] key_byte_o,
  output logic [ksc_pkg::LEN_W-1:0]  used_length_o,
  output logic                       wrapped_o
);

  localparam int unsigned AW    = $clog2(KEY_BYTES);
  localparam int unsigned LEN_W = ksc_pkg::LEN_W;
  localparam int unsigned SUM_W = ksc_pkg::SUM_W;
  localparam int unsigned BW    = ksc_pkg::BYTE_W;
  localparam int unsigned PW    = SUM_W + ksc_pkg::RECIP_W;
  localparam logic [AW-1:0]    LAST_K  = AW'(KEY_BYTES - 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(KEY_BYTES);

  // latched item
  logic [ksc_pkg::CMD_W-1:0] cmd_q;
  logic [ksc_pkg::VAL_W-1:0] add_q;
  logic [LEN_W-1:0]          slen_q;
  logic [ksc_pkg::IDX_W-1:0] ridx_q;

  logic             ascii_q;
  logic [LEN_W-1:0] used_q;
  logic             wrap_q;

  // carry walk, position counted from the least significant byte
  logic [AW-1:0]    k_q;
  logic [SUM_W-1:0] carry_q, t_q, q_q;
  logic             hit_q;

  // key store: addressed from the low end, invalid entries read as zero
  logic [BW-1:0]        mem [KEY_BYTES];
  logic [KEY_BYTES-1:0] vld_q;
  logic [BW-1:0]        rdata_q;
  logic                 rvld_q;

  logic             out_valid_q;
  logic [BW-1:0]    kb_q;
  logic [LEN_W-1:0] len_q;
  logic             wrp_q;

  logic [LEN_W-1:0] slen_c;
  logic [AW-1:0]    slen_k;
  logic [LEN_W-1:0] rk_full;
  logic             hit;
  logic             re;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [BW-1:0]    wdata;
  logic [BW-1:0]    rbyte;
  logic [BW-1:0]    digit_in;
  logic [PW-1:0]    prod;
  logic [SUM_W-1:0] base;
  logic             stop;
  logic             top;
  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] digit_out;
  logic [BW-1:0]    wb_byte;
  logic [LEN_W-1:0] reach;

  // clamp start length into 1..KEY_BYTES
  always_comb begin
    if (slen_q == '0) begin
      slen_c = LEN_W'(1);
    end else if (slen_q > MAX_LEN) begin
      slen_c = MAX_LEN;
    end else begin
      slen_c = slen_q;
    end
  end
  assign slen_k = AW'(slen_c - LEN_W'(1));

  assign hit     = LEN_W'(ridx_q) < used_q;
  assign rk_full = used_q - LEN_W'(1) - LEN_W'(ridx_q);

  assign rbyte    = rvld_q ? rdata_q : '0;
  assign digit_in = ascii_q ? ksc_pkg::ascii_digit(rbyte) : rbyte;
  assign prod     = PW'(t_q) * PW'(ksc_pkg::RECIP_M);

  assign base      = ascii_q ? ksc_pkg::ASCII_BASE : ksc_pkg::BIN_BASE;
  assign stop      = t_q < base;
  assign top       = k_q == LAST_K;
  assign rem       = t_q - SUM_W'(q_q * ksc_pkg::ASCII_BASE);
  assign digit_out = stop ? t_q : rem;
  assign wb_byte   = ascii_q ? (BW'(digit_out) + ksc_pkg::ASCII_LO) : t_q[BW-1:0];
  assign reach     = LEN_W'(k_q) + LEN_W'(1);

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (cmd_i.rd_issue) begin
      re    = 1'b1;
      raddr = rk_full[AW-1:0];
    end else if (cmd_i.add_start) begin
      re    = 1'b1;
      raddr = '0;
    end else if (cmd_i.wb && !stop && !top) begin
      re    = 1'b1;
      raddr = k_q + AW'(1);
    end
  end

  assign we    = cmd_i.init || cmd_i.wb;
  assign waddr = cmd_i.init ? slen_k : k_q;
  assign wdata = cmd_i.init ? BW'(1) : wb_byte;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.init) begin
        // only the leading one survives an init
        vld_q <= KEY_BYTES'(1) << slen_k;
      end else if (cmd_i.wb) begin
        vld_q[k_q] <= 1'b1;
      end
      if (re) begin
        rvld_q <= vld_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= cmd_code_i;
      add_q  <= add_value_i;
      slen_q <= start_length_i;
      ridx_q <= read_index_i;
    end
    if (cmd_i.rd_issue) begin
      hit_q <= hit;
    end
    if (cmd_i.add_start) begin
      k_q     <= '0;
      carry_q <= SUM_W'(add_q);
    end else if (cmd_i.wb) begin
      k_q     <= k_q + AW'(1);
      carry_q <= q_q;
    end
    if (cmd_i.sum) begin
      t_q <= carry_q + SUM_W'(digit_in);
    end
    if (cmd_i.mul) begin
      q_q <= ascii_q ? SUM_W'(prod >> ksc_pkg::RECIP_SH) : (t_q >> BW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ascii_q <= 1'b0;
      used_q  <= '0;
      wrap_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ascii_q <= ascii_only_i;
      end
      if (cmd_i.init) begin
        used_q <= slen_c;
        wrap_q <= 1'b0;
      end else if (cmd_i.wb) begin
        if (stop) begin
          if (reach > used_q) begin
            used_q <= reach;
          end
        end else if (top) begin
          wrap_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      kb_q  <= (cmd_q == ksc_pkg::CMD_READ && hit_q) ? rbyte : '0;
      len_q <= used_q;
      wrp_q <= wrap_q;
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.stop     = stop;
  assign sts_o.top      = top;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign key_byte_o    = kb_q;
  assign used_length_o = len_q;
  assign wrapped_o     = wrp_q;

endmodule

[design/ksc_checker.sv]
module ksc_checker #(
  parameter int unsigned KEY_BYTES = ksc_pkg::KEY_BYTES_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [ksc_pkg::LEN_W-1:0] used_length_i
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // items taken whose result has not yet been transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_xfer))
    else $error("ready dropped without an input transfer");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result with no item outstanding");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> pend_q < 2'd2)
    else $error("item taken while another is still in work");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> used_length_i <= ksc_pkg::LEN_W'(KEY_BYTES))
    else $error("used length beyond key size");

endmodule

bind key_space_counter ksc_checker #(
  .KEY_BYTES (KEY_BYTES)
) u_ksc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .used_length_i (out_o.used_length)
);

[tb/sv/ksc_result_check.sv]
`timescale 1ns / 1ps

module ksc_result_check #(
  parameter int unsigned KEY_BYTES = ksc_pkg::KEY_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ksc_in_if    item_i,
  ksc_out_if   result_i,
  ksc_cfg_if   mode_i,
  output int   mismatch_count_o,
  output int   pending_o
);
  import ksc_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic [LEN_W-1:0]  used_length;
    logic              wrapped;
  } key_result_t;

  logic [BYTE_W-1:0] key_mem [KEY_BYTES];
  logic [LEN_W-1:0]  used_len;
  logic              wrap_seen;
  logic              ascii_mode;
  key_result_t       expected_results [$];
  int                mismatches;

  assign mismatch_count_o = mismatches;

  // Apply one item to the shadow key and return the result it should produce.
  function automatic key_result_t next_key_result(
    input logic [CMD_W-1:0] cmd,
    input logic [VAL_W-1:0] addv,
    input logic [LEN_W-1:0] slen,
    input logic [IDX_W-1:0] ridx
  );
    key_result_t res;
    int unsigned carry, radix, digit, total, lead, reach;
    int          pos, stop_at;
    res = '0;
    case (cmd)
      CMD_INIT: begin
        lead = (slen == 0) ? 1 : ((slen > KEY_BYTES) ? KEY_BYTES : slen);
        foreach (key_mem[i]) key_mem[i] = '0;
        key_mem[KEY_BYTES - lead] = BYTE_W'(1);
        used_len  = LEN_W'(lead);
        wrap_seen = 1'b0;
      end
      CMD_ADD: begin
        carry   = addv;
        radix   = ascii_mode ? ASCII_BASE : BIN_BASE;
        stop_at = -1;
        for (pos = KEY_BYTES - 1; pos >= 0 && stop_at < 0; pos--) begin
          // non-printable bytes read as the nearest end of the alphabet
          if (!ascii_mode) digit = key_mem[pos];
          else if (key_mem[pos] < ASCII_LO) digit = 0;
          else if (key_mem[pos] > ASCII_HI) digit = ASCII_HI - ASCII_LO;
          else digit = key_mem[pos] - ASCII_LO;
          total = carry + digit;
          if (total >= radix) begin
            carry = total / radix;
            total = total % radix;
          end else begin
            stop_at = pos;
          end
          key_mem[pos] = ascii_mode ? BYTE_W'(total + ASCII_LO) : BYTE_W'(total);
        end
        if (stop_at < 0) begin
          wrap_seen = 1'b1;
        end else begin
          reach = KEY_BYTES - stop_at;
          if (reach > used_len) used_len = LEN_W'(reach);
        end
      end
      CMD_READ: begin
        if (ridx < used_len) res.key_byte = key_mem[KEY_BYTES - used_len + ridx];
      end
      default: ;
    endcase
    res.used_length = used_len;
    res.wrapped     = wrap_seen;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_result_t want;
    if (!rst_ni) begin
      foreach (key_mem[i]) key_mem[i] = '0;
      used_len   = '0;
      wrap_seen  = 1'b0;
      ascii_mode = 1'b0;
      expected_results.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (mode_i.valid && mode_i.ready) ascii_mode = mode_i.ascii_only;
      if (item_i.valid && item_i.ready) begin
        expected_results.push_back(next_key_result(item_i.cmd, item_i.add_value,
                                                   item_i.start_length, item_i.read_index));
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: key_byte %0d used_length %0d wrapped %0d",
                 result_i.key_byte, result_i.used_length, result_i.wrapped);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result_i.key_byte !== want.key_byte) begin
            $error("key_byte: expected %0d, actual %0d", want.key_byte, result_i.key_byte);
            mismatches++;
          end
          if (result_i.used_length !== want.used_length) begin
            $error("used_length: expected %0d, actual %0d",
                   want.used_length, result_i.used_length);
            mismatches++;
          end
          if (result_i.wrapped !== want.wrapped) begin
            $error("wrapped: expected %0d, actual %0d", want.wrapped, result_i.wrapped);
            mismatches++;
          end
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

[tb/sv/tb_key_space_counter.sv]
`timescale 1ns / 1ps

module tb_key_space_counter;
  import ksc_pkg::*;

  // cmd encoding the block must treat as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 88;
  // give the controller room to settle
  localparam int unsigned SETTLE_CYCLES = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          calm;         // when set, neither side idles
  int unsigned cycles = 0;
  int          mismatches;
  int          pending;

  ksc_in_if  item_ch ();
  ksc_out_if result_ch ();
  ksc_cfg_if mode_ch ();

  key_space_counter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_ch),
    .out_o  (result_ch),
    .cfg_i  (mode_ch)
  );

  ksc_result_check u_result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item_ch),
    .result_i         (result_ch),
    .mode_i           (mode_ch),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("key_space_counter regression: fail");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [VAL_W-1:0] rnd_val();
    return VAL_W'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] rnd_len();
    return LEN_W'($urandom);
  endfunction

  function automatic logic [IDX_W-1:0] rnd_idx();
    return IDX_W'($urandom);
  endfunction

  // Hold valid low for a random gap, then present the item and hold it until
  // the transfer happens. Valid stays high on return so a back-to-back item
  // needs no second assignment in the same step.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] addv,
                           input logic [LEN_W-1:0] slen, input logic [IDX_W-1:0] ridx);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid        <= 1'b1;
    item_ch.cmd          <= cmd;
    item_ch.add_value    <= addv;
    item_ch.start_length <= slen;
    item_ch.read_index   <= ridx;
    do @(posedge clk_i); while (!item_ch.ready);
  endtask

  // Drop valid and stall intake until every outstanding result has come back,
  // then let the controller fall back to idle.
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic ascii);
    mode_ch.valid      <= 1'b1;
    mode_ch.ascii_only <= ascii;
    do @(posedge clk_i); while (!mode_ch.ready);
    mode_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: short keys, adds that keep carries going,
  // reads that land inside the used bytes. Unused fields carry random noise.
  task automatic send_random_item();
    int unsigned      pick, lead;
    logic [VAL_W-1:0] amount;
    logic [IDX_W-1:0] offset;
    logic [CMD_W-1:0] cmd;
    pick   = $urandom_range(0, 99);
    amount = rnd_val();
    offset = rnd_idx();
    lead   = $urandom_range(0, 511);
    if (pick < 8) begin
      cmd = CMD_INIT;
      case ($urandom_range(0, 9))
        0:       ;
        1, 2:    lead = $urandom_range(1, 256);
        default: lead = $urandom_range(1, 12);
      endcase
    end else if (pick < 60) begin
      cmd = CMD_ADD;
      case ($urandom_range(0, 5))
        0, 1:    amount = VAL_W'($urandom_range(0, 255));
        2:       amount = VAL_W'($urandom_range(0, 93));
        3:       amount = 16'hFFFF - VAL_W'($urandom_range(0, 15));
        default: ;
      endcase
    end else if (pick < 95) begin
      cmd = CMD_READ;
      if ($urandom_range(0, 4) != 0) offset = IDX_W'($urandom_range(0, 15));
    end else begin
      cmd = CMD_UNUSED;
    end
    send_item(cmd, amount, LEN_W'(lead), offset);
  endtask

  // Result side: stall ready for a random count before each transfer.
  initial begin
    int unsigned stall;
    result_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
    end
  end

  initial begin
    calm                 = 1'b0;
    rst_ni               <= 1'b0;
    item_ch.valid        <= 1'b0;
    item_ch.cmd          <= CMD_INIT;
    item_ch.add_value    <= '0;
    item_ch.start_length <= '0;
    item_ch.read_index   <= '0;
    mode_ch.valid        <= 1'b0;
    mode_ch.ascii_only   <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Binary counting: reads before any init, a no-op command, clamping of the
    // start length at both ends, full-width adds and reads past the used bytes.
    set_mode(1'b0);
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd0);
    send_item(CMD_UNUSED, rnd_val(), rnd_len(), rnd_idx());
    send_item(CMD_ADD,    16'd0,     rnd_len(), rnd_idx());
    send_item(CMD_INIT,   rnd_val(), 9'd0,      rnd_idx());
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd0);
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd255);
    send_item(CMD_INIT,   rnd_val(), 9'd511,    rnd_idx());
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd255);
    send_item(CMD_INIT,   rnd_val(), 9'd256,    rnd_idx());
    send_item(CMD_INIT,   rnd_val(), 9'd1,      rnd_idx());
    send_item(CMD_ADD,    16'hFFFF,  rnd_len(), rnd_idx());
    send_item(CMD_ADD,    16'hFFFF,  rnd_len(), rnd_idx());
    send_item(CMD_ADD,    16'd1,     rnd_len(), rnd_idx());
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd0);
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd1);
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd2);
    drain();

    // Printable counting: zero bytes read as spaces, an add of zero rewrites
    // the low byte, and carries cross the base-94 boundary.
    set_mode(1'b1);
    send_item(CMD_INIT,   rnd_val(), 9'd3,      rnd_idx());
    send_item(CMD_ADD,    16'd0,     rnd_len(), rnd_idx());
    send_item(CMD_ADD,    16'd93,    rnd_len(), rnd_idx());
    send_item(CMD_ADD,    16'd1,     rnd_len(), rnd_idx());
    send_item(CMD_ADD,    16'hFFFF,  rnd_len(), rnd_idx());
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd0);
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd1);
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd2);
    send_item(CMD_READ,   rnd_val(), rnd_len(), 8'd3);

    // Random phases; each starts idle with a fresh mode, some run without gaps.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      drain();
      set_mode(phase % 3 != 0);
      calm = (phase == 2) || (phase == 5);
      send_item(CMD_INIT, rnd_val(), LEN_W'($urandom_range(1, 8)), rnd_idx());
      repeat (PHASE_ITEMS - 1) send_random_item();
    end
    calm = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("key_space_counter regression: pass");
    end else begin
      $display("key_space_counter regression: fail");
    end
    $finish;
  end

endmodule
